[rtl/core/kss_pkg.sv]
// shared types and constants for the kth smallest stream selector
package kss_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RANK_W = 7;
  localparam logic [RANK_W-1:0] RANK_RESET = 7'd1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic ins;
    logic clr;
  } cell_ctrl_t;

endpackage

[rtl/core/kss_cell.sv]
// one cell of the sorted insertion chain
module kss_cell
  import kss_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  data_t      new_val,
  input  logic       prev_gt,
  input  data_t      prev_val,
  input  logic       prev_valid,
  output logic       gt,
  output data_t      val,
  output logic       valid
);

  data_t val_next;
  logic  valid_next;

  // an empty cell counts as larger than anything
  assign gt = !valid || (val > new_val);

  always_comb begin
    val_next   = val;
    valid_next = valid;
    if (ctrl.clr) begin
      valid_next = 1'b0;
    end else if (ctrl.ins && gt) begin
      val_next   = prev_gt ? prev_val : new_val;
      valid_next = prev_gt ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/core/kth_smallest_stream_select.sv]
// kth smallest stream selector: top level with the cell chain and result register
// a request marked last sets flush; the result register then loads once the output is free
// one request per cycle, but none is taken while flush is set after a request marked last
// the flush reads the cell chosen by rank_k and empties the whole chain
// the chain holds the K_MAX smallest values in ascending order, one per cell
// reset (rst, synchronous) empties the chain, drops any result and sets rank_k to 1
module kth_smallest_stream_select
  import kss_pkg::*;
#(
  parameter int unsigned K_MAX = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,   // value
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W-1:0]   m_tdata,   // kth_value
  output logic                m_tuser,   // found
  input  logic                cfg_we,
  input  logic [RANK_W-1:0]   cfg_wdata
);

  logic [RANK_W-1:0] rank_k;
  logic              flush;
  logic              in_fire;
  logic              out_load;
  cell_ctrl_t        ctrl;
  data_t             new_val;

  logic  gt    [K_MAX];
  data_t val   [K_MAX];
  logic  valid [K_MAX];

  logic  sel_found;
  data_t sel_val;

  assign s_tready = !flush;
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = flush && (!m_tvalid || m_tready);
  assign new_val  = $signed(s_tdata);
  assign ctrl.ins = in_fire;
  assign ctrl.clr = rst || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= RANK_RESET;
    end else if (cfg_we) begin
      rank_k <= cfg_wdata;
    end
  end

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      kss_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_val    (new_val),
        .prev_gt    (1'b0),
        .prev_val   (new_val),
        .prev_valid (1'b1),
        .gt         (gt[i]),
        .val        (val[i]),
        .valid      (valid[i])
      );
    end else begin : g_body
      kss_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_val    (new_val),
        .prev_gt    (gt[i-1]),
        .prev_val   (val[i-1]),
        .prev_valid (valid[i-1]),
        .gt         (gt[i]),
        .val        (val[i]),
        .valid      (valid[i])
      );
    end
  end

  // rank select over the settled chain
  always_comb begin
    sel_found = 1'b0;
    sel_val   = '0;
    for (int i = 0; i < K_MAX; i++) begin
      if ((int'(rank_k) == i + 1) && valid[i]) begin
        sel_found = 1'b1;
        sel_val   = sel_val | val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush <= 1'b0;
    end else if (in_fire && s_tlast) begin
      flush <= 1'b1;
    end else if (out_load) begin
      flush <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= sel_val;
      m_tuser <= sel_found;
    end
  end

endmodule

[rtl/core/kss_checker.sv]
// port checker for the kth smallest stream selector and its bind
module kss_checker
  import kss_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              s_tlast,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_pause_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("request taken in the cycle after a last request");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a preceding last request");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not found result carries a value");

endmodule

bind kth_smallest_stream_select kss_checker u_kss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
